// ----- rtl/i2cbm_pkg.sv -----
// shared types and constants for the byte-level i2c master
package i2cbm_pkg;

   // command codes carried by a request
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   // csr register indexes
   typedef enum logic [1:0] {
      CSR_SETUP_TICKS = 2'd0,
      CSR_HIGH_TICKS  = 2'd1,
      CSR_LOW_TICKS   = 2'd2,
      CSR_COND_TICKS  = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 16;
   localparam int BYTE_W     = 8;
   localparam int BITCNT_W   = 4;

   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [BYTE_W-1:0]     byte_type;

   localparam csr_data_type SETUP_TICKS_RST = 16'd20;
   localparam csr_data_type HIGH_TICKS_RST  = 16'd100;
   localparam csr_data_type LOW_TICKS_RST   = 16'd200;
   localparam csr_data_type COND_TICKS_RST  = 16'd200;

   // ack phase follows this many data bits
   localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

endpackage

// ----- rtl/i2cbm_req_if.sv -----
// request channel: one bus tick with sampled sda and an optional command
interface i2cbm_req_if;
   import i2cbm_pkg::*;

   logic         valid;
   logic         ready;
   logic         cmd_valid;
   cmd_kind_type kind;
   byte_type     tx_byte;
   logic         send_nack;
   logic         sda_in;

   modport source (output valid, output cmd_valid, output kind, output tx_byte,
                   output send_nack, output sda_in, input ready);
   modport sink   (input valid, input cmd_valid, input kind, input tx_byte,
                   input send_nack, input sda_in, output ready);
endinterface

// ----- rtl/i2cbm_rsp_if.sv -----
// response channel: line levels and status after one bus tick
interface i2cbm_rsp_if;
   import i2cbm_pkg::*;

   logic     valid;
   logic     ready;
   logic     scl_out;
   logic     sda_out;
   logic     busy_res;
   logic     done_res;
   logic     nack_seen;
   byte_type rx_byte;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output nack_seen, output rx_byte, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input nack_seen, input rx_byte, output ready);
endinterface

// ----- rtl/i2c_byte_master.sv -----
// byte-level i2c master: start, stop, write byte and read byte sequencer
//
// usage
//   every request on req_bus is one tick of bus timing: it carries the sampled
//   sda level and, while the master is idle, an optional command (cmd_valid,
//   kind, tx_byte, send_nack). commands offered while busy are dropped.
//   every request yields exactly one response on rsp_bus with the scl/sda
//   levels to drive (1 = released), busy, a one-tick done pulse, nack_seen
//   on the done of a write that got no acknowledge, and the last read byte.
//   phase lengths come from four 16-bit tick registers written via csr_*
//   (setup, high, low, cond); zero counts as one tick, lengths above the
//   tick counter range saturate. write them only while idle.
// timing
//   the response to a request is registered at the accepting edge.
//   throughput is one request per cycle while no response is stalled, set by the
//   single state update between the state registers and the response register.
// reset and stall
//   synchronous reset returns to idle with both lines released and the tick
//   registers at 20/100/200/200. a stalled response is held; req_bus.ready
//   falls only while a response waits and rsp_bus.ready is low.
module i2c_byte_master #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   i2cbm_req_if.sink                  req_bus,
   i2cbm_rsp_if.source                rsp_bus,
   input  logic                       csr_wr_en,
   input  i2cbm_pkg::csr_index_type   csr_index,
   input  i2cbm_pkg::csr_data_type    csr_wr_data
);
   import i2cbm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START_A   = 4'd1,
      PH_START_B   = 4'd2,
      PH_STOP_A    = 4'd3,
      PH_STOP_B    = 4'd4,
      PH_BIT_SETUP = 4'd5,
      PH_BIT_HIGH  = 4'd6,
      PH_BIT_LOW   = 4'd7,
      PH_ACK_SETUP = 4'd8,
      PH_ACK_HIGH  = 4'd9,
      PH_ACK_LOW   = 4'd10
   } phase_type;

   // compare width covers both the 16-bit registers and the tick counter
   localparam int CW = (TICK_WIDTH > CSR_DATA_W) ? TICK_WIDTH + 1 : CSR_DATA_W + 1;
   localparam logic [CW-1:0] TICK_CAP = CW'((64'd1 << TICK_WIDTH) - 64'd1);

   // tick registers
   csr_data_type setup_ticks_ff, high_ticks_ff, low_ticks_ff, cond_ticks_ff;

   // sequencer state
   phase_type           phase_ff, phase_in;
   logic [BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   byte_type            shift_ff, shift_in;
   cmd_kind_type        active_cmd_ff, active_cmd_in;
   logic                nack_latch_ff, nack_latch_in;
   logic                ack_choice_ff, ack_choice_in;
   logic                scl_line_ff, scl_line_in;
   logic                sda_line_ff, sda_line_in;
   byte_type            rx_last_ff, rx_last_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_nack_ff;
   byte_type            rsp_rx_ff;

   logic                accept;
   logic                done_tick, nack_tick;
   csr_data_type        len_sel;
   logic [CW-1:0]       len_raw, len_eff, cnt_inc;
   logic                expire;
   byte_type            shift_left;
   logic [BITCNT_W-1:0] bit_count_inc;

   // handshake: a waiting response only blocks when the receiver stalls
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.scl_out   = rsp_scl_ff;
   assign rsp_bus.sda_out   = rsp_sda_ff;
   assign rsp_bus.busy_res  = rsp_busy_ff;
   assign rsp_bus.done_res  = rsp_done_ff;
   assign rsp_bus.nack_seen = rsp_nack_ff;
   assign rsp_bus.rx_byte   = rsp_rx_ff;

   // length of the current phase
   always_comb begin
      unique case (phase_ff)
         PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: len_sel = cond_ticks_ff;
         PH_BIT_SETUP, PH_ACK_SETUP:                   len_sel = setup_ticks_ff;
         PH_BIT_HIGH, PH_ACK_HIGH:                     len_sel = high_ticks_ff;
         default:                                      len_sel = low_ticks_ff;
      endcase
   end

   always_comb begin
      len_raw = CW'(len_sel);
      len_eff = (len_raw == '0) ? CW'(1) : len_raw;
      if (len_eff > TICK_CAP) begin
         len_eff = TICK_CAP;
      end
   end

   assign cnt_inc       = CW'(tick_ff) + CW'(1);
   assign expire        = (cnt_inc >= len_eff);
   assign shift_left    = {shift_ff[BYTE_W-2:0], 1'b0};
   assign bit_count_inc = bit_count_ff + BITCNT_W'(1);

   // next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      tick_in       = tick_ff;
      shift_in      = shift_ff;
      active_cmd_in = active_cmd_ff;
      nack_latch_in = nack_latch_ff;
      ack_choice_in = ack_choice_ff;
      scl_line_in   = scl_line_ff;
      sda_line_in   = sda_line_ff;
      rx_last_in    = rx_last_ff;
      done_tick     = 1'b0;
      nack_tick     = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_bus.cmd_valid) begin
               active_cmd_in = req_bus.kind;
               nack_latch_in = 1'b0;
               bit_count_in  = '0;
               tick_in       = '0;
               unique case (req_bus.kind)
                  CMD_START: begin
                     phase_in    = PH_START_A;
                     scl_line_in = 1'b1;
                     sda_line_in = 1'b1;
                  end
                  CMD_STOP: begin
                     phase_in    = PH_STOP_A;
                     scl_line_in = 1'b0;
                     sda_line_in = 1'b0;
                  end
                  CMD_WRITE: begin
                     shift_in    = req_bus.tx_byte;
                     phase_in    = PH_BIT_SETUP;
                     scl_line_in = 1'b0;
                     sda_line_in = req_bus.tx_byte[BYTE_W-1];
                  end
                  default: begin
                     shift_in      = '0;
                     ack_choice_in = req_bus.send_nack;
                     phase_in      = PH_BIT_SETUP;
                     scl_line_in   = 1'b0;
                     sda_line_in   = 1'b1;
                  end
               endcase
            end
         end
         PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_BIT_SETUP, PH_BIT_HIGH,
         PH_BIT_LOW, PH_ACK_SETUP, PH_ACK_HIGH, PH_ACK_LOW: begin
            tick_in = cnt_inc[TICK_WIDTH-1:0];
            if (expire) begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_START_A: begin
                     phase_in    = PH_START_B;
                     scl_line_in = 1'b1;
                     sda_line_in = 1'b0;
                  end
                  PH_START_B: begin
                     phase_in    = PH_IDLE;
                     scl_line_in = 1'b0;
                     sda_line_in = 1'b0;
                     done_tick   = 1'b1;
                  end
                  PH_STOP_A: begin
                     phase_in    = PH_STOP_B;
                     scl_line_in = 1'b1;
                     sda_line_in = 1'b0;
                  end
                  PH_STOP_B: begin
                     phase_in    = PH_IDLE;
                     scl_line_in = 1'b1;
                     sda_line_in = 1'b1;
                     done_tick   = 1'b1;
                     nack_tick   = nack_latch_ff;
                  end
                  PH_BIT_SETUP, PH_ACK_SETUP: begin
                     phase_in    = (phase_ff == PH_BIT_SETUP) ? PH_BIT_HIGH : PH_ACK_HIGH;
                     scl_line_in = 1'b1;
                  end
                  PH_BIT_HIGH: begin
                     // read data sampled at the end of scl high
                     if (active_cmd_ff == CMD_READ) begin
                        shift_in = {shift_ff[BYTE_W-2:0], req_bus.sda_in};
                     end
                     phase_in    = PH_BIT_LOW;
                     scl_line_in = 1'b0;
                  end
                  PH_BIT_LOW: begin
                     if (active_cmd_ff == CMD_WRITE) begin
                        shift_in = shift_left;
                     end
                     bit_count_in = bit_count_inc;
                     scl_line_in  = 1'b0;
                     if (bit_count_inc >= BITS_PER_BYTE) begin
                        phase_in    = PH_ACK_SETUP;
                        sda_line_in = (active_cmd_ff == CMD_READ) ? ack_choice_ff : 1'b1;
                     end else begin
                        phase_in    = PH_BIT_SETUP;
                        sda_line_in = (active_cmd_ff == CMD_WRITE) ?
                                      shift_left[BYTE_W-1] : 1'b1;
                     end
                  end
                  PH_ACK_HIGH: begin
                     if (active_cmd_ff == CMD_WRITE) begin
                        nack_latch_in = req_bus.sda_in;
                     end
                     phase_in    = PH_ACK_LOW;
                     scl_line_in = 1'b0;
                  end
                  default: begin
                     // end of ack: a refused write closes with a stop
                     if (active_cmd_ff == CMD_WRITE && nack_latch_ff) begin
                        phase_in    = PH_STOP_A;
                        scl_line_in = 1'b0;
                        sda_line_in = 1'b0;
                     end else begin
                        phase_in    = PH_IDLE;
                        scl_line_in = 1'b0;
                        sda_line_in = 1'b1;
                        done_tick   = 1'b1;
                        if (active_cmd_ff == CMD_READ) begin
                           rx_last_in = shift_ff;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            // unused phase code: back to idle without done
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ticks_ff <= SETUP_TICKS_RST;
         high_ticks_ff  <= HIGH_TICKS_RST;
         low_ticks_ff   <= LOW_TICKS_RST;
         cond_ticks_ff  <= COND_TICKS_RST;
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         tick_ff        <= '0;
         shift_ff       <= '0;
         active_cmd_ff  <= CMD_START;
         nack_latch_ff  <= 1'b0;
         ack_choice_ff  <= 1'b0;
         scl_line_ff    <= 1'b1;
         sda_line_ff    <= 1'b1;
         rx_last_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SETUP_TICKS: setup_ticks_ff <= csr_wr_data;
               CSR_HIGH_TICKS:  high_ticks_ff  <= csr_wr_data;
               CSR_LOW_TICKS:   low_ticks_ff   <= csr_wr_data;
               default:         cond_ticks_ff  <= csr_wr_data;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            tick_ff       <= tick_in;
            shift_ff      <= shift_in;
            active_cmd_ff <= active_cmd_in;
            nack_latch_ff <= nack_latch_in;
            ack_choice_ff <= ack_choice_in;
            scl_line_ff   <= scl_line_in;
            sda_line_ff   <= sda_line_in;
            rx_last_ff    <= rx_last_in;
         end
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff  <= scl_line_in;
         rsp_sda_ff  <= sda_line_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_done_ff <= done_tick;
         rsp_nack_ff <= done_tick && nack_tick && (active_cmd_in == CMD_WRITE);
         rsp_rx_ff   <= rx_last_in;
      end
   end

endmodule
